// ===== hdl/ipv4hp_pkg.sv =====
package ipv4hp_pkg;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Field limits
   localparam int ACC_W = 17;
   localparam logic [ACC_W-1:0] ACC_MAX   = 17'h1FFFF;
   localparam logic [ACC_W-1:0] OCTET_MAX = 17'd255;
   localparam logic [ACC_W-1:0] PORT_MAX  = 17'd65535;

   // Field positions
   localparam logic [2:0] FIELD_LAST_OCTET = 3'd3;
   localparam logic [2:0] FIELD_PORT       = 3'd4;

   typedef logic [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] host_addr;
      logic [15:0] port_num;
   } result_type;

endpackage

// ===== hdl/ipv4hp_if.sv =====
// Character stream into the parser
interface ipv4hp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// Parsed address and port out of the parser
interface ipv4hp_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] host_addr;
   logic [15:0] port_num;

   modport source (output valid, output ok, output host_addr, output port_num, input ready);
   modport sink   (input valid, input ok, input host_addr, input port_num, output ready);
endinterface

// ===== hdl/ipv4hp_core.sv =====
// Parse state and its per-character update.
module ipv4hp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              char_code,
   output ipv4hp_pkg::result_type  result
);
   import ipv4hp_pkg::*;

   logic [2:0]  field_index_ff, field_index_in;
   acc_type     decimal_acc_ff, decimal_acc_in;
   logic        digit_seen_ff, digit_seen_in;
   logic        error_flag_ff, error_flag_in;
   logic [31:0] octets_ff, octets_in;

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [20:0] acc_times_ten;
   logic [20:0] acc_sum;
   logic        octet_good;
   logic        ok;

   // Decode the character and form the next accumulator value
   always_comb begin
      is_digit      = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
      digit_val     = 4'(char_code - CH_ZERO);
      acc_times_ten = ({4'b0, decimal_acc_ff} << 3) + ({4'b0, decimal_acc_ff} << 1);
      acc_sum       = acc_times_ten + {17'b0, digit_val};
      octet_good    = digit_seen_ff && (decimal_acc_ff <= OCTET_MAX);
   end

   // Result seen when the terminating NUL is taken
   always_comb begin
      ok = !error_flag_ff && (field_index_ff == FIELD_PORT) && digit_seen_ff &&
           (decimal_acc_ff <= PORT_MAX);
      result.ok        = ok;
      result.host_addr = ok ? octets_ff : 32'b0;
      result.port_num  = ok ? decimal_acc_ff[15:0] : 16'b0;
   end

   // Next state
   always_comb begin
      field_index_in = field_index_ff;
      decimal_acc_in = decimal_acc_ff;
      digit_seen_in  = digit_seen_ff;
      error_flag_in  = error_flag_ff;
      octets_in      = octets_ff;
      priority if (char_code == CH_NUL) begin
         field_index_in = '0;
         decimal_acc_in = '0;
         digit_seen_in  = 1'b0;
         error_flag_in  = 1'b0;
         octets_in      = '0;
      end else if (error_flag_ff) begin
         // ignore everything until the NUL
      end else if (is_digit) begin
         decimal_acc_in = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
         digit_seen_in  = 1'b1;
      end else if ((char_code == CH_DOT && field_index_ff < FIELD_LAST_OCTET) ||
                   (char_code == CH_COLON && field_index_ff == FIELD_LAST_OCTET)) begin
         if (octet_good) begin
            octets_in      = {octets_ff[23:0], decimal_acc_ff[7:0]};
            field_index_in = field_index_ff + 3'd1;
            decimal_acc_in = '0;
            digit_seen_in  = 1'b0;
         end else begin
            error_flag_in = 1'b1;
         end
      end else begin
         // misplaced separator or any other byte
         error_flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= '0;
         decimal_acc_ff <= '0;
         digit_seen_ff  <= 1'b0;
         error_flag_ff  <= 1'b0;
         octets_ff      <= '0;
      end else if (step_en) begin
         field_index_ff <= field_index_in;
         decimal_acc_ff <= decimal_acc_in;
         digit_seen_ff  <= digit_seen_in;
         error_flag_ff  <= error_flag_in;
         octets_ff      <= octets_in;
      end
   end

endmodule

// ===== hdl/ipv4_host_port_text_parser.sv =====
// Streaming parser for text of the form a.b.c.d:port.
//
// req carries one character per transfer (char_code). A NUL character ends
// the string; every other character only updates the parse state and gives
// no result. On the NUL, rsp carries one transfer with ok, host_addr (first
// octet in bits 31:24) and port_num; host_addr and port_num are zero when ok
// is low. The parse state then clears for the next string.
//
// Throughput is one character per cycle unless a NUL waits on a stalled rsp:
// the character sits in an input register, the parse state updates from it,
// and a result goes into an output register. A NUL on req is held in the
// input register and then in the output register, which drives rsp.valid.
//
// When rsp stalls, characters other than NUL keep flowing; a NUL waits in
// the input register until the output register frees, and req.ready drops
// behind it.
//
// Reset (synchronous, active high) empties both registers and clears the
// parse state; no result is pending after reset.
module ipv4_host_port_text_parser (
   input  logic          clock,
   input  logic          reset,
   ipv4hp_req_if.sink    req,
   ipv4hp_rsp_if.source  rsp
);
   import ipv4hp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   result_type core_result;
   logic       is_nul;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // Stage control
   always_comb begin
      is_nul    = (in_char_ff == CH_NUL);
      out_free  = !out_valid_ff || rsp.ready;
      advance   = in_valid_ff && (!is_nul || out_free);
      req.ready = !in_valid_ff || advance;
      req_take  = req.valid && req.ready;

      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance && is_nul) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   ipv4hp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .char_code (in_char_ff),
      .result    (core_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_char_ff <= req.char_code;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && is_nul) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.ok        = out_data_ff.ok;
   assign rsp.host_addr = out_data_ff.host_addr;
   assign rsp.port_num  = out_data_ff.port_num;

endmodule

// ===== hdl/ipv4hp_checker.sv =====
// Port-level checks for the address and port parser.
module ipv4hp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [31:0] rsp_host_addr,
   input logic [15:0] rsp_port_num
);
   import ipv4hp_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_host_addr) && $stable(rsp_port_num))
      else $error("stalled result changed");

   // A failed parse reports zero address and port
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_host_addr == 32'b0 && rsp_port_num == 16'b0)
      else $error("failed result carries nonzero fields");

   // No result pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A fresh result follows a NUL transfer on req
   a_result_from_nul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_char_code == CH_NUL, 2))
      else $error("result without terminating NUL");

endmodule

bind ipv4_host_port_text_parser ipv4hp_checker u_ipv4hp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_char_code (req.char_code),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_ok        (rsp.ok),
   .rsp_host_addr (rsp.host_addr),
   .rsp_port_num  (rsp.port_num)
);
